[rtl/core/tbn_pkg.sv]
package tbn_pkg;

    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int DW = 33;          // width of one edge or UV delta
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
    } t_vertex;

    typedef struct packed {
        logic signed [15:0] tangent_x;
        logic signed [15:0] tangent_y;
        logic signed [15:0] tangent_z;
        logic signed [15:0] binormal_x;
        logic signed [15:0] binormal_y;
        logic signed [15:0] binormal_z;
        logic               degenerate;
    } t_result;

    typedef struct packed {
        logic signed [DW-1:0] e1x;
        logic signed [DW-1:0] e1y;
        logic signed [DW-1:0] e1z;
        logic signed [DW-1:0] e2x;
        logic signed [DW-1:0] e2y;
        logic signed [DW-1:0] e2z;
        logic signed [DW-1:0] du1;
        logic signed [DW-1:0] dv1;
        logic signed [DW-1:0] du2;
        logic signed [DW-1:0] dv2;
    } t_delta;

    function automatic logic signed [DW-1:0] sub32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        sub32 = $signed({a[31], a}) - $signed({b[31], b});
    endfunction

endpackage

[rtl/core/tbn_front.sv]
module tbn_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  tbn_pkg::t_vertex  i_vertex,
    output logic              o_push,
    output tbn_pkg::t_delta   o_delta,
    input  logic              i_full
);
    import tbn_pkg::*;

    logic [1:0]         r_phase;
    logic signed [31:0] r_hx [2];
    logic signed [31:0] r_hy [2];
    logic signed [31:0] r_hz [2];
    logic signed [31:0] r_hu [2];
    logic signed [31:0] r_hv [2];
    logic               acc;

    // third vertex needs room in the queue
    assign o_ready = (r_phase != 2'd2) || !i_full;
    assign acc     = i_valid && o_ready;
    assign o_push  = acc && (r_phase == 2'd2);

    // form the deltas against the first held vertex
    always_comb begin
        o_delta.e1x = sub32(r_hx[1], r_hx[0]);
        o_delta.e1y = sub32(r_hy[1], r_hy[0]);
        o_delta.e1z = sub32(r_hz[1], r_hz[0]);
        o_delta.e2x = sub32(i_vertex.pos_x, r_hx[0]);
        o_delta.e2y = sub32(i_vertex.pos_y, r_hy[0]);
        o_delta.e2z = sub32(i_vertex.pos_z, r_hz[0]);
        o_delta.du1 = sub32(r_hu[1], r_hu[0]);
        o_delta.dv1 = sub32(r_hv[1], r_hv[0]);
        o_delta.du2 = sub32(i_vertex.tex_u, r_hu[0]);
        o_delta.dv2 = sub32(i_vertex.tex_v, r_hv[0]);
    end

    // advance the phase and hold the first two vertices
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
        end else if (acc) begin
            if (r_phase == 2'd2) begin
                r_phase <= 2'd0;
            end else begin
                r_phase <= r_phase + 2'd1;
            end
        end
        if (acc && r_phase != 2'd2) begin
            r_hx[r_phase[0]] <= i_vertex.pos_x;
            r_hy[r_phase[0]] <= i_vertex.pos_y;
            r_hz[r_phase[0]] <= i_vertex.pos_z;
            r_hu[r_phase[0]] <= i_vertex.tex_u;
            r_hv[r_phase[0]] <= i_vertex.tex_v;
        end
    end

endmodule

[rtl/core/tbn_queue.sv]
module tbn_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tbn_pkg::t_delta  i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output tbn_pkg::t_delta  o_data
);
    import tbn_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_delta          r_mem [QUEUE_DEPTH];
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_rp;
    logic [AW:0]     r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    // advance pointers and count, and write a pushed entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

[rtl/core/tbn_back.sv]
module tbn_back #(
    parameter int OUT_FRAC_BITS = tbn_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  tbn_pkg::t_delta   i_q_data,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output tbn_pkg::t_result  o_result
);
    import tbn_pkg::*;

    localparam int CW = 2 * DW + 1;            // cross product width
    localparam int NW = 31 + OUT_FRAC_BITS;    // dividend width
    localparam int QW = OUT_FRAC_BITS + 1;     // quotient width

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_LOAD, S_NORM, S_SQ, S_SQRT, S_DIVI, S_DIV, S_OUT
    } t_state;

    t_state                r_state;
    t_delta                r_d;
    logic [4:0]            r_cnt;
    logic signed [2*DW-1:0] r_prod;
    logic signed [2*DW-1:0] r_acc;
    logic signed [CW-1:0]  r_det;
    logic signed [CW-1:0]  r_vec [6];
    logic [CW-1:0]         r_mag [3];
    logic                  r_neg [3];
    logic [29:0]           r_c [3];
    logic [61:0]           r_s;
    logic [32:0]           r_rem;
    logic [30:0]           r_root;
    logic [QW-1:0]         r_n;
    logic [QW-1:0]         r_q;
    logic [1:0]            r_j;
    logic                  r_vi;
    logic                  r_deg;
    logic signed [15:0]    r_res [6];
    logic                  r_ovalid;
    t_result               r_out;

    logic signed [DW-1:0]  op_a, op_b;
    logic signed [2*DW-1:0] prod;
    logic [CW-1:0]         mag_or;
    logic [34:0]           sq_rem, sq_trial;
    logic [32:0]           dv_rem;
    logic [NW-1:0]         numer;
    logic [QW-1:0]         q_full;
    logic [31:0]           q_ext;
    logic [15:0]           q_sat;
    logic                  flip;
    logic [2:0]            res_idx;

    // select multiplier operands for each step
    always_comb begin
        op_a = '0;
        op_b = '0;
        if (r_state == S_SQ) begin
            if (r_cnt[1:0] != 2'd3) begin
                op_a = $signed({3'b000, r_c[r_cnt[1:0]]});
                op_b = op_a;
            end
        end else begin
            case (r_cnt)
                5'd0:  begin op_a = r_d.du1; op_b = r_d.dv2; end
                5'd1:  begin op_a = r_d.du2; op_b = r_d.dv1; end
                5'd2:  begin op_a = r_d.dv2; op_b = r_d.e1x; end
                5'd3:  begin op_a = r_d.dv1; op_b = r_d.e2x; end
                5'd4:  begin op_a = r_d.dv2; op_b = r_d.e1y; end
                5'd5:  begin op_a = r_d.dv1; op_b = r_d.e2y; end
                5'd6:  begin op_a = r_d.dv2; op_b = r_d.e1z; end
                5'd7:  begin op_a = r_d.dv1; op_b = r_d.e2z; end
                5'd8:  begin op_a = r_d.du1; op_b = r_d.e2x; end
                5'd9:  begin op_a = r_d.du2; op_b = r_d.e1x; end
                5'd10: begin op_a = r_d.du1; op_b = r_d.e2y; end
                5'd11: begin op_a = r_d.du2; op_b = r_d.e1y; end
                5'd12: begin op_a = r_d.du1; op_b = r_d.e2z; end
                5'd13: begin op_a = r_d.du2; op_b = r_d.e1z; end
                default: begin op_a = '0; op_b = '0; end
            endcase
        end
        prod = op_a * op_b;
    end

    // datapath helpers for normalise, root and divide
    always_comb begin
        mag_or   = r_mag[0] | r_mag[1] | r_mag[2];
        sq_rem   = {r_rem, r_s[61:60]};
        sq_trial = {2'b00, r_root, 2'b01};
        dv_rem   = {r_rem[31:0], r_n[QW-1]};
        numer    = (NW'(r_c[r_j]) << OUT_FRAC_BITS) + NW'(r_root[30:1]);
        q_full   = {r_q[QW-2:0], (dv_rem >= {2'b00, r_root})};
        q_ext    = 32'(q_full);
        q_sat    = (q_ext > 32'd32767) ? 16'd32767 : q_ext[15:0];
        flip     = r_det[CW-1];
        res_idx  = r_vi ? 3'(r_j) + 3'd3 : 3'(r_j);
    end

    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign o_valid  = r_ovalid;
    assign o_result = r_out;

    // sequence one triangle through the shared units
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            // drop a taken beat unless a new one replaces it
            if (r_ovalid && i_ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_d     <= i_q_data;
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= prod;
                    if (r_cnt != 5'd0) begin
                        if (!r_cnt[0]) begin
                            if (r_cnt == 5'd2) begin
                                r_det <= CW'(r_acc) - CW'(r_prod);
                            end else begin
                                r_vec[3'(r_cnt[4:1] - 4'd2)] <= CW'(r_acc) - CW'(r_prod);
                            end
                        end else begin
                            r_acc <= r_prod;
                        end
                    end
                    if (r_cnt == 5'd14) begin
                        r_vi    <= 1'b0;
                        r_state <= S_LOAD;
                    end
                    r_cnt <= r_cnt + 5'd1;
                end
                S_LOAD: begin
                    for (int k = 0; k < 3; k++) begin
                        r_neg[k] <= r_vi ? r_vec[k+3][CW-1] : r_vec[k][CW-1];
                        r_mag[k] <= r_vi ? (r_vec[k+3][CW-1] ? -r_vec[k+3] : r_vec[k+3])
                                         : (r_vec[k][CW-1] ? -r_vec[k] : r_vec[k]);
                    end
                    if (r_det == '0) begin
                        r_deg   <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (mag_or == '0) begin
                        r_deg   <= 1'b1;
                        r_state <= S_OUT;
                    end else if (mag_or[CW-1]) begin
                        for (int k = 0; k < 3; k++) begin
                            r_c[k] <= r_mag[k][CW-1:CW-30];
                        end
                        r_cnt   <= '0;
                        r_s     <= '0;
                        r_state <= S_SQ;
                    end else if (mag_or[CW-1:CW-8] == '0) begin
                        for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] << 8;
                    end else begin
                        for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] << 1;
                    end
                end
                S_SQ: begin
                    r_prod <= prod;
                    if (r_cnt != 5'd0) begin
                        r_s <= r_s + r_prod[61:0];
                    end
                    if (r_cnt == 5'd3) begin
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_SQRT: begin
                    r_s <= r_s << 2;
                    if (sq_rem >= sq_trial) begin
                        r_rem  <= 33'(sq_rem - sq_trial);
                        r_root <= {r_root[29:0], 1'b1};
                    end else begin
                        r_rem  <= sq_rem[32:0];
                        r_root <= {r_root[29:0], 1'b0};
                    end
                    if (r_cnt == 5'd30) begin
                        r_j     <= '0;
                        r_state <= S_DIVI;
                    end
                    r_cnt <= r_cnt + 5'd1;
                end
                S_DIVI: begin
                    r_rem   <= 33'(numer[NW-1:QW]);
                    r_n     <= numer[QW-1:0];
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_n <= r_n << 1;
                    r_q <= q_full;
                    r_rem <= q_full[0] ? dv_rem - {2'b00, r_root} : dv_rem;
                    if (r_cnt == 5'(QW - 1)) begin
                        r_res[res_idx] <= (r_neg[r_j] != flip) ? -q_sat : q_sat;
                        if (r_j == 2'd2) begin
                            if (!r_vi) begin
                                r_vi    <= 1'b1;
                                r_state <= S_LOAD;
                            end else begin
                                r_deg   <= 1'b0;
                                r_state <= S_OUT;
                            end
                        end else begin
                            r_j     <= r_j + 2'd1;
                            r_state <= S_DIVI;
                        end
                    end
                    r_cnt <= r_cnt + 5'd1;
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid         <= 1'b1;
                        r_out.degenerate <= r_deg;
                        r_out.tangent_x  <= r_deg ? '0 : r_res[0];
                        r_out.tangent_y  <= r_deg ? '0 : r_res[1];
                        r_out.tangent_z  <= r_deg ? '0 : r_res[2];
                        r_out.binormal_x <= r_deg ? '0 : r_res[3];
                        r_out.binormal_y <= r_deg ? '0 : r_res[4];
                        r_out.binormal_z <= r_deg ? '0 : r_res[5];
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/core/triangle_tangent_binormal_core.sv]
// Flow: a vertex beat is taken while o_ready is high; the third vertex of a triangle waits
// while the two-entry queue is full. The back end forms 14 products, then per vector runs
// normalise steps, a 31-step root and three divides, all on one shared datapath; a zero
// determinant skips them and answers as degenerate. The back end works on one triangle at
// a time, so the serial root and divider set the rate; the queue holds up to two more.
// Reset: synchronous, active low; clears vertex phase, queue and sequencer, no sweep.
module triangle_tangent_binormal_core #(
    parameter int OUT_FRAC_BITS = tbn_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  tbn_pkg::t_vertex  i_vertex,
    output logic              o_valid,
    input  logic              i_ready,
    output tbn_pkg::t_result  o_result
);
    import tbn_pkg::*;

    logic   push, full, q_valid, pop;
    t_delta push_data, q_data;

    tbn_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_vertex(i_vertex), .o_push(push), .o_delta(push_data), .i_full(full)
    );

    tbn_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(push_data),
        .o_full(full), .o_valid(q_valid), .i_pop(pop), .o_data(q_data)
    );

    tbn_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .i_q_data(q_data),
        .o_q_pop(pop), .o_valid(o_valid), .i_ready(i_ready), .o_result(o_result)
    );

endmodule

[rtl/core/tbn_checker.sv]
module tbn_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_ready,
    input tbn_pkg::t_result  o_result
);
    // hold a stalled result beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result))
        else $error("result beat dropped or changed while stalled");

    // degenerate beats carry zero vectors
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.degenerate |->
            o_result.tangent_x == 0 && o_result.tangent_y == 0 &&
            o_result.tangent_z == 0 && o_result.binormal_x == 0 &&
            o_result.binormal_y == 0 && o_result.binormal_z == 0)
        else $error("degenerate result with non-zero vector");

    // a good tangent is never all zero
    a_unit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.degenerate |->
            o_result.tangent_x != 0 || o_result.tangent_y != 0 ||
            o_result.tangent_z != 0)
        else $error("non-degenerate tangent is zero");

    // no result straight out of reset
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid after reset");
endmodule

bind triangle_tangent_binormal_core tbn_checker u_tbn_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid),
    .i_ready(i_ready), .o_result(o_result)
);
